FILE: hw/rtl/fern_pkg.sv
// ----------------------------------------------------------------------------
// fern_pkg
// Shared types and constants of the fern point generator: map codes,
// item and result records, configuration record, map coefficients.
// ----------------------------------------------------------------------------
package fern_pkg;

  // affine map chosen by the selector
  typedef enum logic [1:0] {
    MAP_STEM  = 2'd0,
    MAP_LEFT  = 2'd1,
    MAP_RIGHT = 2'd2,
    MAP_MAIN  = 2'd3
  } map_e;

  // classified item passed from front to back
  typedef struct packed {
    map_e map;
    logic restart;
  } item_t;

  // configuration registers
  typedef struct packed {
    logic        [31:0] zoom_x;
    logic        [31:0] zoom_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
  } cfg_t;

  // one result
  typedef struct packed {
    logic               plot;
    logic        [9:0]  pixel_x;
    logic        [9:0]  pixel_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } result_t;

  // map coefficients, Q1.24; y bias is in Q24 units
  typedef struct packed {
    logic signed [25:0] kxx;
    logic signed [25:0] kxy;
    logic signed [25:0] kyx;
    logic signed [25:0] kyy;
    logic signed [25:0] by;
  } coef_t;

  // register indexes
  localparam logic [1:0] REG_ZOOM_X   = 2'd0;
  localparam logic [1:0] REG_ZOOM_Y   = 2'd1;
  localparam logic [1:0] REG_OFFSET_X = 2'd2;
  localparam logic [1:0] REG_OFFSET_Y = 2'd3;

  localparam logic [31:0] ZOOM_RESET = 32'd6553600;

  // fixed point coefficients
  localparam logic signed [25:0] K_0_16 = 26'sd2684355;
  localparam logic signed [25:0] K_0_15 = 26'sd2516582;
  localparam logic signed [25:0] K_0_28 = 26'sd4697620;
  localparam logic signed [25:0] K_0_26 = 26'sd4362076;
  localparam logic signed [25:0] K_0_24 = 26'sd4026532;
  localparam logic signed [25:0] K_0_44 = 26'sd7381975;
  localparam logic signed [25:0] K_0_20 = 26'sd3355443;
  localparam logic signed [25:0] K_0_23 = 26'sd3858760;
  localparam logic signed [25:0] K_0_22 = 26'sd3690988;
  localparam logic signed [25:0] K_1_6  = 26'sd26843546;
  localparam logic signed [25:0] K_0_85 = 26'sd14260634;
  localparam logic signed [25:0] K_0_04 = 26'sd671089;

  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;

  // zoom products at or above this magnitude are out of range
  localparam logic [63:0] PROD_LIMIT = 64'h4000_0000_0000_0000;

  // coefficient set of a map
  function automatic coef_t map_coef(input map_e m);
    coef_t c;
    case (m)
      MAP_STEM: begin
        c = '{kxx: '0, kxy: '0, kyx: '0, kyy: K_0_16, by: '0};
      end
      MAP_LEFT: begin
        c = '{kxx: -K_0_15, kxy: K_0_28, kyx: K_0_26, kyy: K_0_24, by: K_0_44};
      end
      MAP_RIGHT: begin
        c = '{kxx: K_0_20, kxy: -K_0_26, kyx: K_0_23, kyy: K_0_22, by: K_1_6};
      end
      default: begin
        c = '{kxx: K_0_85, kxy: K_0_04, kyx: -K_0_04, kyy: K_0_85, by: K_1_6};
      end
    endcase
    return c;
  endfunction

  // q48 sum to q24: add one half, floor, saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [59:0] s);
    logic signed [59:0] t;
    logic        [35:0] q;
    t = s + 60'sd8388608;
    q = t[59:24];
    if (q[35:31] == {5{q[35]}}) begin
      return $signed(q[31:0]);
    end else if (q[35]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

FILE: hw/rtl/fern_front.sv
// ----------------------------------------------------------------------------
// fern_front
// Input side: accepts items, classifies the selector into a map code and
// holds classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module fern_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [6:0]        rand_sel_i,
  input  logic              restart_i,
  output logic              full_o,
  output fern_pkg::item_t   item_o,
  output logic              avail_o,
  input  logic              take_i
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  fern_pkg::item_t que_q [QDepth];
  fern_pkg::item_t item_in;
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  // selector classification
  always_comb begin
    item_in.restart = restart_i;
    if (rand_sel_i == 7'd0) begin
      item_in.map = fern_pkg::MAP_STEM;
    end else if (rand_sel_i <= 7'd7) begin
      item_in.map = fern_pkg::MAP_LEFT;
    end else if (rand_sel_i <= 7'd15) begin
      item_in.map = fern_pkg::MAP_RIGHT;
    end else begin
      item_in.map = fern_pkg::MAP_MAIN;
    end
  end

  // queue control
  assign full_o  = (cnt_q == CntW'(QDepth));
  assign avail_o = (cnt_q != '0);
  assign item_o  = que_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = take_i && avail_o;

  always_comb begin
    wr_d  = wr_en ? wr_q + 1'b1 : wr_q;
    rd_d  = rd_en ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      que_q[wr_q] <= item_in;
    end
  end

endmodule

FILE: hw/rtl/fern_back.sv
// ----------------------------------------------------------------------------
// fern_back
// Execution side: a sequencer steps one coefficient multiplier and one zoom
// multiplier through the affine map and the screen mapping, then writes the
// result register.
// ----------------------------------------------------------------------------
module fern_back #(
  parameter int unsigned SCREEN_W = 1024,
  parameter int unsigned SCREEN_H = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fern_pkg::item_t   item_i,
  input  logic              avail_i,
  output logic              take_o,
  input  fern_pkg::cfg_t    cfg_i,
  input  logic              pop_i,
  output logic              empty_o,
  output fern_pkg::result_t res_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_XX = 4'd1;
  localparam logic [3:0] ST_MUL_XY = 4'd2;
  localparam logic [3:0] ST_MUL_YX = 4'd3;
  localparam logic [3:0] ST_MUL_YY = 4'd4;
  localparam logic [3:0] ST_ACC_Y  = 4'd5;
  localparam logic [3:0] ST_ZOOM_X = 4'd6;
  localparam logic [3:0] ST_SCR_X  = 4'd7;
  localparam logic [3:0] ST_ZOOM_Y = 4'd8;
  localparam logic [3:0] ST_SCR_Y  = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  localparam logic signed [63:0] BaseX = $signed(64'(SCREEN_W / 2) << 40);
  localparam logic signed [63:0] LimX  = $signed(64'(SCREEN_W) << 40);
  localparam logic signed [63:0] LimY  = $signed(64'(SCREEN_H) << 40);

  logic [3:0]         st_q, st_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] x_q, y_q;
  fern_pkg::map_e     map_q;
  fern_pkg::coef_t    coef;

  logic signed [31:0] mul_op;
  logic signed [25:0] mul_k;
  logic signed [57:0] prod_d, prod_q;
  logic signed [59:0] prod_ext, bias_y, acc_d, acc_q;
  logic signed [31:0] nx_q, ny_q;

  logic signed [31:0] dp, doff;
  logic [32:0]        diff, ndiff;
  logic [31:0]        dmag_q, zsel;
  logic               dneg_q;
  logic [63:0]        zprod_d, zprod_q;
  logic signed [63:0] sbase, sval;
  logic signed [63:0] sx_q, sy_q;
  logic               okx_q, oky_q;

  logic               done_fire;
  logic               plot_d;
  fern_pkg::result_t  res_d, res_q;

  // sequencer
  always_comb begin
    st_d   = st_q;
    take_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (avail_i) begin
          take_o = 1'b1;
          st_d   = ST_MUL_XX;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || pop_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = st_q + 4'd1;
      end
    endcase
  end

  assign done_fire   = (st_q == ST_DONE) && (!out_valid_q || pop_i);
  assign out_valid_d = done_fire || (out_valid_q && !pop_i);
  assign empty_o     = !out_valid_q;
  assign res_o       = res_q;

  // coefficient multiplier operands
  assign coef = fern_pkg::map_coef(map_q);

  always_comb begin
    case (st_q)
      ST_MUL_XX: begin
        mul_op = x_q;
        mul_k  = coef.kxx;
      end
      ST_MUL_XY: begin
        mul_op = y_q;
        mul_k  = coef.kxy;
      end
      ST_MUL_YX: begin
        mul_op = x_q;
        mul_k  = coef.kyx;
      end
      ST_MUL_YY: begin
        mul_op = y_q;
        mul_k  = coef.kyy;
      end
      default: begin
        mul_op = x_q;
        mul_k  = '0;
      end
    endcase
  end

  assign prod_d   = mul_op * mul_k;
  assign prod_ext = $signed({{2{prod_q[57]}}, prod_q});
  assign bias_y   = $signed({{10{coef.by[25]}}, coef.by, 24'b0});

  // accumulator
  always_comb begin
    case (st_q)
      ST_MUL_XY: acc_d = prod_ext;
      ST_MUL_YY: acc_d = bias_y + prod_ext;
      default:   acc_d = acc_q + prod_ext;
    endcase
  end

  // distance from the view offset, as sign and magnitude
  always_comb begin
    if (st_q == ST_SCR_X) begin
      dp   = ny_q;
      doff = cfg_i.offset_y;
    end else begin
      dp   = nx_q;
      doff = cfg_i.offset_x;
    end
    diff  = {dp[31], dp} - {doff[31], doff};
    ndiff = 33'd0 - diff;
  end

  // zoom multiplier and screen coordinate
  assign zsel    = (st_q == ST_ZOOM_Y) ? cfg_i.zoom_y : cfg_i.zoom_x;
  assign zprod_d = {32'b0, dmag_q} * {32'b0, zsel};
  assign sbase   = (st_q == ST_SCR_X) ? BaseX : 64'sd0;
  assign sval    = dneg_q ? sbase - $signed(zprod_q) : sbase + $signed(zprod_q);

  // result assembly
  assign plot_d = okx_q && oky_q && (sx_q > 64'sd0) && (sx_q < LimX)
               && (sy_q > 64'sd0) && (sy_q < LimY);

  always_comb begin
    res_d.plot    = plot_d;
    res_d.pixel_x = plot_d ? sx_q[49:40] : 10'd0;
    res_d.pixel_y = plot_d ? sy_q[49:40] : 10'd0;
    res_d.point_x = nx_q;
    res_d.point_y = ny_q;
  end

  // control state and current point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      if (take_o && item_i.restart) begin
        x_q <= '0;
        y_q <= '0;
      end else if (done_fire) begin
        x_q <= nx_q;
        y_q <= ny_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    zprod_q <= zprod_d;
    if (take_o) begin
      map_q <= item_i.map;
    end
    if (st_q == ST_MUL_YY) begin
      nx_q <= fern_pkg::round_sat(acc_q);
    end
    if (st_q == ST_ZOOM_X) begin
      ny_q <= fern_pkg::round_sat(acc_q);
    end
    if (st_q == ST_ACC_Y || st_q == ST_SCR_X) begin
      dneg_q <= diff[32];
      dmag_q <= diff[32] ? ndiff[31:0] : diff[31:0];
    end
    if (st_q == ST_SCR_X) begin
      sx_q  <= sval;
      okx_q <= zprod_q < fern_pkg::PROD_LIMIT;
    end
    if (st_q == ST_SCR_Y) begin
      sy_q  <= sval;
      oky_q <= zprod_q < fern_pkg::PROD_LIMIT;
    end
    if (done_fire) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: hw/rtl/fern_ifs_point_generator.sv
// ----------------------------------------------------------------------------
// fern_ifs_point_generator
// Barnsley fern iterated function system point generator with screen mapping.
// ----------------------------------------------------------------------------
// Usage
// - input queue port: push with rand_sel_i and restart_i; a transfer happens
//   when push is high and full is low. restart_i puts the point back at the
//   origin before the map is applied.
// - result queue port: while empty is low the oldest result sits on plot_o,
//   pixel_x_o, pixel_y_o, point_x_o and point_y_o; pop takes it.
// - apb port: zoom_x, zoom_y, offset_x, offset_y at byte addresses 0, 4, 8,
//   12; write only while no item is in flight. pready is tied high.
// - the back end sequencer takes one item at a time and steps one
//   coefficient multiplier and one zoom multiplier through it before it
//   takes the next item from the front queue.
// - a two entry queue between front and back, plus the result register,
//   keeps input transfers going while a result waits.
// - reset: point at the origin, zooms at 100.0, offsets at zero, queues
//   empty.
// - when pop stays low the result is held; the back end finishes the next
//   item and waits, then the front queue fills and full goes high.
// ----------------------------------------------------------------------------
module fern_ifs_point_generator #(
  parameter int unsigned SCREEN_W = 1024,
  parameter int unsigned SCREEN_H = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input queue port
  input  logic               push,
  output logic               full,
  input  logic [6:0]         rand_sel_i,
  input  logic               restart_i,
  // result queue port
  output logic               empty,
  input  logic               pop,
  output logic               plot_o,
  output logic [9:0]         pixel_x_o,
  output logic [9:0]         pixel_y_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  fern_pkg::cfg_t    cfg_q;
  fern_pkg::item_t   item;
  fern_pkg::result_t res;
  logic              avail;
  logic              take;
  logic              cfg_we;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom_x   <= fern_pkg::ZOOM_RESET;
      cfg_q.zoom_y   <= fern_pkg::ZOOM_RESET;
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        fern_pkg::REG_ZOOM_X:   cfg_q.zoom_x   <= pwdata;
        fern_pkg::REG_ZOOM_Y:   cfg_q.zoom_y   <= pwdata;
        fern_pkg::REG_OFFSET_X: cfg_q.offset_x <= $signed(pwdata);
        fern_pkg::REG_OFFSET_Y: cfg_q.offset_y <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      fern_pkg::REG_ZOOM_X:   prdata = cfg_q.zoom_x;
      fern_pkg::REG_ZOOM_Y:   prdata = cfg_q.zoom_y;
      fern_pkg::REG_OFFSET_X: prdata = cfg_q.offset_x;
      fern_pkg::REG_OFFSET_Y: prdata = cfg_q.offset_y;
      default:                prdata = '0;
    endcase
  end

  // front end: accept and classify
  fern_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rand_sel_i (rand_sel_i),
    .restart_i  (restart_i),
    .full_o     (full),
    .item_o     (item),
    .avail_o    (avail),
    .take_i     (take)
  );

  // back end: map, screen transform, result register
  fern_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item),
    .avail_i (avail),
    .take_o  (take),
    .cfg_i   (cfg_q),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res)
  );

  assign plot_o    = res.plot;
  assign pixel_x_o = res.pixel_x;
  assign pixel_y_o = res.pixel_y;
  assign point_x_o = res.point_x;
  assign point_y_o = res.point_y;

endmodule
